// File: sv/sblc_pkg.sv
package sblc_pkg;

    localparam int MAX_RESULTS = 32;
    localparam int EMIT_W      = 6;

    localparam logic [2:0] OP_TICK  = 3'd0;
    localparam logic [2:0] OP_RXBYTE = 3'd1;
    localparam logic [2:0] OP_READY = 3'd2;
    localparam logic [2:0] OP_LOAD  = 3'd3;
    localparam logic [2:0] OP_SEND  = 3'd4;

    localparam logic [1:0] CFG_OWN_ID   = 2'd0;
    localparam logic [1:0] CFG_PRIORITY = 2'd1;
    localparam logic [1:0] CFG_IDLE     = 2'd2;

    localparam logic [7:0] OWN_ID_RESET   = 8'd128;
    localparam logic [3:0] PRIORITY_RESET = 4'd8;
    localparam logic [4:0] IDLE_RESET     = 5'd11;
    localparam logic [7:0] BACKOFF_MASK   = 8'h07;
    localparam logic [7:0] COLL_MAX       = 8'd255;

    typedef struct packed {
        logic [2:0] op;
        logic [7:0] data_byte;
        logic [4:0] tx_index;
        logic [5:0] tx_length;
    } in_item_t;

    typedef struct packed {
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       rx_valid;
        logic [7:0] rx_byte;
        logic       rx_end;
        logic       checksum_error;
        logic       rx_overflow;
        logic       send_pending;
        logic       bus_busy;
        logic       last;
    } out_item_t;

    typedef struct packed {
        logic capture;
        logic exec;
        logic load_emit;
    } cmd_t;

    typedef struct packed {
        logic emit_start;
        logic emit_more;
    } status_t;

endpackage

// File: sv/serial_bus_link_controller_top.sv
// Link-layer controller for a byte bus, one op per input transfer. An op that
// gives a single result is accepted, executed and then held for output until
// its result is transferred. A packet end gives one result per stored byte,
// at most 32, each going through the registered receive-store read (read,
// load, output). The next op is accepted once the last result of the current
// one has been transferred. The stores need no clearing after reset.
module serial_bus_link_controller_top #(
    parameter int RX_DEPTH = 32,
    parameter int TX_DEPTH = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  sblc_pkg::in_item_t   in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output sblc_pkg::out_item_t  out_data,
    input  logic                 cfg_write,
    input  logic [1:0]           cfg_index,
    input  logic [7:0]           cfg_data
);

    sblc_pkg::cmd_t    cmd;
    sblc_pkg::status_t status;

    sblc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    sblc_datapath #(
        .RX_DEPTH (RX_DEPTH),
        .TX_DEPTH (TX_DEPTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status),
        .out_data  (out_data)
    );

endmodule

// File: sv/sblc_datapath.sv
module sblc_datapath #(
    parameter int RX_DEPTH = 32,
    parameter int TX_DEPTH = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  sblc_pkg::in_item_t   in_data,
    input  logic                 cfg_write,
    input  logic [1:0]           cfg_index,
    input  logic [7:0]           cfg_data,
    input  sblc_pkg::cmd_t       cmd,
    output sblc_pkg::status_t    status,
    output sblc_pkg::out_item_t  out_data
);

    localparam int RX_AW = $clog2(RX_DEPTH);
    localparam int TX_AW = $clog2(TX_DEPTH);
    localparam int RX_CW = $clog2(RX_DEPTH + 1);
    localparam int TX_CW = $clog2(TX_DEPTH + 1);
    localparam int EW    = sblc_pkg::EMIT_W;

    logic [7:0] rx_mem [RX_DEPTH];
    logic [7:0] tx_mem [TX_DEPTH];
    logic [7:0] rx_rd_reg;
    logic [7:0] tx_rd_reg;

    sblc_pkg::in_item_t item_reg;

    logic [7:0] own_id_reg;
    logic [3:0] priority_reg;
    logic [4:0] idle_reg;

    logic [RX_CW-1:0] rx_count_reg, rx_count_next;
    logic             ovf_reg, ovf_next;
    logic [TX_CW-1:0] send_len_reg, send_len_next;
    logic [TX_CW-1:0] send_pos_reg, send_pos_next;
    logic [7:0]       sum_reg, sum_next;
    logic [7:0]       coll_reg, coll_next;
    logic [4:0]       tt_reg, tt_next;
    logic [4:0]       tc_reg, tc_next;
    logic             tr_reg, tr_next;
    logic xmit_reg, xmit_next, pend_reg, pend_next, busy_reg, busy_next;
    logic csum_reg, csum_next, idsent_reg, idsent_next, backoff_reg, backoff_next;
    logic waitidle_reg, waitidle_next, prio_reg, prio_next;

    logic [EW-1:0] emit_idx_reg, emit_idx_next;
    logic [EW-1:0] emit_n_reg, emit_n_next;
    logic          emit_ce_reg, emit_ce_next;
    logic          emit_ov_reg, emit_ov_next;

    logic          res_txv;
    logic [7:0]    res_txb;
    logic          emit_start;
    logic          rx_we;
    logic          tx_we;
    logic [4:0]    cnt1;
    logic [7:0]    cc1;
    logic [4:0]    boff;
    logic [EW-1:0] pkt_n;

    sblc_pkg::out_item_t out_reg;
    sblc_pkg::out_item_t out_next;

    always_ff @(posedge clk)
    begin
        if (rx_we)
        begin
            rx_mem[RX_AW'(rx_count_reg)] <= item_reg.data_byte;
        end
        rx_rd_reg <= rx_mem[RX_AW'(32'(emit_idx_reg))];
    end

    always_ff @(posedge clk)
    begin
        if (tx_we)
        begin
            tx_mem[TX_AW'(item_reg.tx_index)] <= item_reg.data_byte;
        end
        tx_rd_reg <= tx_mem[TX_AW'(send_pos_reg)];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            item_reg <= in_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_id_reg   <= sblc_pkg::OWN_ID_RESET;
            priority_reg <= sblc_pkg::PRIORITY_RESET;
            idle_reg     <= sblc_pkg::IDLE_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                sblc_pkg::CFG_OWN_ID:   own_id_reg   <= cfg_data;
                sblc_pkg::CFG_PRIORITY: priority_reg <= cfg_data[3:0];
                sblc_pkg::CFG_IDLE:     idle_reg     <= cfg_data[4:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        rx_count_next = rx_count_reg;
        ovf_next      = ovf_reg;
        send_len_next = send_len_reg;
        send_pos_next = send_pos_reg;
        sum_next      = sum_reg;
        coll_next     = coll_reg;
        tt_next       = tt_reg;
        tc_next       = tc_reg;
        tr_next       = tr_reg;
        xmit_next     = xmit_reg;
        pend_next     = pend_reg;
        busy_next     = busy_reg;
        csum_next     = csum_reg;
        idsent_next   = idsent_reg;
        backoff_next  = backoff_reg;
        waitidle_next = waitidle_reg;
        prio_next     = prio_reg;
        emit_idx_next = emit_idx_reg;
        emit_n_next   = emit_n_reg;
        emit_ce_next  = emit_ce_reg;
        emit_ov_next  = emit_ov_reg;
        res_txv       = 1'b0;
        res_txb       = 8'd0;
        emit_start    = 1'b0;
        rx_we         = 1'b0;
        tx_we         = 1'b0;
        cnt1          = tc_reg + 5'd1;
        cc1           = (coll_reg < sblc_pkg::COLL_MAX) ? coll_reg + 8'd1 : coll_reg;
        boff          = 5'(cc1 & sblc_pkg::BACKOFF_MASK);
        pkt_n         = (32'(rx_count_reg) > sblc_pkg::MAX_RESULTS)
                        ? EW'(sblc_pkg::MAX_RESULTS) : EW'(rx_count_reg);
        if (boff == 5'd0)
        begin
            boff = 5'd8;
        end

        if (cmd.exec)
        begin
            case (item_reg.op)
                sblc_pkg::OP_TICK:
                begin
                    if (tr_reg)
                    begin
                        tc_next = cnt1;
                        if (cnt1 == tt_reg)
                        begin
                            tr_next   = 1'b0;
                            tc_next   = 5'd0;
                            busy_next = 1'b0;
                            if (backoff_reg || prio_reg)
                            begin
                                if (backoff_reg)
                                begin
                                    backoff_next = 1'b0;
                                    coll_next    = 8'd0;
                                end
                                else
                                begin
                                    prio_next = 1'b0;
                                end
                                res_txv     = 1'b1;
                                res_txb     = own_id_reg;
                                sum_next    = own_id_reg;
                                idsent_next = 1'b1;
                            end
                            else if (!xmit_reg)
                            begin
                                emit_start    = (pkt_n != '0);
                                emit_idx_next = '0;
                                emit_n_next   = pkt_n;
                                emit_ce_next  = (sum_reg != 8'd0);
                                emit_ov_next  = ovf_reg ||
                                    (32'(rx_count_reg) > sblc_pkg::MAX_RESULTS);
                                rx_count_next = '0;
                                ovf_next      = 1'b0;
                                sum_next      = 8'd0;
                                if (pend_reg)
                                begin
                                    tt_next   = {1'b0, priority_reg};
                                    tc_next   = 5'd0;
                                    tr_next   = 1'b1;
                                    prio_next = 1'b1;
                                end
                            end
                        end
                    end
                end
                sblc_pkg::OP_RXBYTE:
                begin
                    prio_next    = 1'b0;
                    backoff_next = 1'b0;
                    if (xmit_reg)
                    begin
                        if (csum_reg)
                        begin
                            xmit_next     = 1'b0;
                            csum_next     = 1'b0;
                            waitidle_next = 1'b0;
                        end
                    end
                    else if (!idsent_reg)
                    begin
                        busy_next = 1'b1;
                        tt_next   = idle_reg;
                        tc_next   = 5'd0;
                        tr_next   = 1'b1;
                        if (32'(rx_count_reg) < RX_DEPTH)
                        begin
                            rx_we         = 1'b1;
                            rx_count_next = rx_count_reg + RX_CW'(1);
                        end
                        else
                        begin
                            ovf_next = 1'b1;
                        end
                        sum_next = sum_reg + item_reg.data_byte;
                    end
                    if (pend_reg && idsent_reg)
                    begin
                        idsent_next = 1'b0;
                        if (item_reg.data_byte == own_id_reg)
                        begin
                            xmit_next = 1'b1;
                        end
                        else
                        begin
                            coll_next = cc1;
                            tc_next   = 5'd0;
                            tr_next   = 1'b1;
                            if (cc1 == 8'd1)
                            begin
                                tt_next = idle_reg;
                            end
                            else
                            begin
                                tt_next      = boff;
                                backoff_next = 1'b1;
                            end
                        end
                    end
                end
                sblc_pkg::OP_READY:
                begin
                    if (xmit_reg && !csum_reg)
                    begin
                        res_txv = 1'b1;
                        if (send_pos_reg < send_len_reg && 32'(send_pos_reg) < TX_DEPTH)
                        begin
                            res_txb       = tx_rd_reg;
                            sum_next      = sum_reg + tx_rd_reg;
                            send_pos_next = send_pos_reg + TX_CW'(1);
                        end
                        else
                        begin
                            send_len_next = '0;
                            res_txb       = 8'd0 - sum_reg;
                            sum_next      = 8'd0;
                            pend_next     = 1'b0;
                            csum_next     = 1'b1;
                        end
                    end
                end
                sblc_pkg::OP_LOAD:
                begin
                    tx_we = (32'(item_reg.tx_index) < TX_DEPTH);
                end
                sblc_pkg::OP_SEND:
                begin
                    if (!pend_reg)
                    begin
                        send_len_next = (32'(item_reg.tx_length) > TX_DEPTH)
                                        ? TX_CW'(TX_DEPTH) : TX_CW'(item_reg.tx_length);
                        send_pos_next = '0;
                        if (!waitidle_reg && !busy_reg)
                        begin
                            tt_next       = idle_reg;
                            tc_next       = 5'd0;
                            tr_next       = 1'b1;
                            waitidle_next = 1'b1;
                        end
                        pend_next = 1'b1;
                    end
                end
                default: ;
            endcase
        end

        if (cmd.load_emit)
        begin
            emit_idx_next = emit_idx_reg + EW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_count_reg <= '0;
            ovf_reg      <= 1'b0;
            send_len_reg <= '0;
            send_pos_reg <= '0;
            sum_reg      <= 8'd0;
            coll_reg     <= 8'd0;
            tt_reg       <= 5'd0;
            tc_reg       <= 5'd0;
            tr_reg       <= 1'b0;
            xmit_reg     <= 1'b0;
            pend_reg     <= 1'b0;
            busy_reg     <= 1'b0;
            csum_reg     <= 1'b0;
            idsent_reg   <= 1'b0;
            backoff_reg  <= 1'b0;
            waitidle_reg <= 1'b0;
            prio_reg     <= 1'b0;
            emit_idx_reg <= '0;
            emit_n_reg   <= '0;
            emit_ce_reg  <= 1'b0;
            emit_ov_reg  <= 1'b0;
        end
        else
        begin
            rx_count_reg <= rx_count_next;
            ovf_reg      <= ovf_next;
            send_len_reg <= send_len_next;
            send_pos_reg <= send_pos_next;
            sum_reg      <= sum_next;
            coll_reg     <= coll_next;
            tt_reg       <= tt_next;
            tc_reg       <= tc_next;
            tr_reg       <= tr_next;
            xmit_reg     <= xmit_next;
            pend_reg     <= pend_next;
            busy_reg     <= busy_next;
            csum_reg     <= csum_next;
            idsent_reg   <= idsent_next;
            backoff_reg  <= backoff_next;
            waitidle_reg <= waitidle_next;
            prio_reg     <= prio_next;
            emit_idx_reg <= emit_idx_next;
            emit_n_reg   <= emit_n_next;
            emit_ce_reg  <= emit_ce_next;
            emit_ov_reg  <= emit_ov_next;
        end
    end

    // result payload is registered; pending and busy come straight from the flags
    always_comb
    begin
        out_next = out_reg;
        if (cmd.exec && !emit_start)
        begin
            out_next          = '0;
            out_next.tx_valid = res_txv;
            out_next.tx_byte  = res_txb;
            out_next.last     = 1'b1;
        end
        else if (cmd.load_emit)
        begin
            out_next                = '0;
            out_next.rx_valid       = 1'b1;
            out_next.rx_byte        = rx_rd_reg;
            out_next.rx_end         = (emit_idx_next == emit_n_reg);
            out_next.last           = (emit_idx_next == emit_n_reg);
            out_next.checksum_error = emit_ce_reg;
            out_next.rx_overflow    = emit_ov_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    always_comb
    begin
        out_data              = out_reg;
        out_data.send_pending = pend_reg;
        out_data.bus_busy     = busy_reg;
    end

    assign status.emit_start = emit_start;
    assign status.emit_more  = (emit_idx_reg != emit_n_reg);

endmodule

// File: sv/sblc_ctrl.sv
module sblc_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    output logic                out_valid,
    input  logic                out_stall,
    input  sblc_pkg::status_t   status,
    output sblc_pkg::cmd_t      cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EXEC = 3'd1;
    localparam logic [2:0] S_READ = 3'd2;
    localparam logic [2:0] S_LOAD = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    logic [2:0] state_reg, state_next;

    always_comb
    begin
        state_next    = state_reg;
        cmd           = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = status.emit_start ? S_READ : S_OUT;
            end
            S_READ:
            begin
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                cmd.load_emit = 1'b1;
                state_next    = S_OUT;
            end
            S_OUT:
            begin
                if (!out_stall)
                begin
                    state_next = status.emit_more ? S_READ : S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = (state_reg == S_OUT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// File: tb/sv/serial_bus_link_controller_top_test.sv
`timescale 1ns / 1ps

module serial_bus_link_controller_top_test;

    localparam logic [7:0] F_XMIT     = 8'h01;
    localparam logic [7:0] F_PEND     = 8'h02;
    localparam logic [7:0] F_BUSY     = 8'h04;
    localparam logic [7:0] F_CSUM     = 8'h08;
    localparam logic [7:0] F_IDSENT   = 8'h10;
    localparam logic [7:0] F_BACKOFF  = 8'h20;
    localparam logic [7:0] F_WAITIDLE = 8'h40;
    localparam logic [7:0] F_PRIO     = 8'h80;
    localparam int         STORE_DEPTH = 32;
    localparam int         ITEM_GOAL   = 470;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    sblc_pkg::in_item_t   in_data;
    logic                 out_valid;
    logic                 out_stall;
    sblc_pkg::out_item_t  out_data;
    logic                 cfg_write;
    logic [1:0]           cfg_index;
    logic [7:0]           cfg_data;

    // link state as the controller should hold it
    logic [7:0]  lk_own_id;
    logic [3:0]  lk_prio;
    logic [4:0]  lk_idle;
    logic [7:0]  lk_rx_mem [STORE_DEPTH];
    logic [7:0]  lk_tx_mem [STORE_DEPTH];
    int          lk_rx_count;
    bit          lk_overflow;
    int          lk_send_len;
    int          lk_send_pos;
    logic [7:0]  lk_sum;
    logic [7:0]  lk_flags;
    logic [7:0]  lk_coll;
    logic [4:0]  lk_tgt;
    logic [4:0]  lk_cnt;
    bit          lk_run;

    sblc_pkg::out_item_t step_bytes [$];
    sblc_pkg::out_item_t pending_results [$];

    int          n_errors;
    int          n_items;
    int          n_results;
    int          n_rx_bytes;
    int          n_tx_bytes;
    int          n_collisions;
    bit          idling;
    int          hold_cycles;
    int          stall_left;

    serial_bus_link_controller_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("timeout with %0d transfers still expected", pending_results.size());
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic void push_byte(logic txv, logic [7:0] txb, logic rxv, logic [7:0] rxb,
                                      logic rend, logic ce, logic ov);
        sblc_pkg::out_item_t r;
        if (step_bytes.size() >= sblc_pkg::MAX_RESULTS)
            return;
        r = '0;
        r.tx_valid       = txv;
        r.tx_byte        = txb;
        r.rx_valid       = rxv;
        r.rx_byte        = rxb;
        r.rx_end         = rend;
        r.checksum_error = ce;
        r.rx_overflow    = ov;
        step_bytes.push_back(r);
    endfunction

    function automatic void arm_timer(logic [4:0] target);
        lk_tgt = target;
        lk_cnt = '0;
        lk_run = 1'b1;
    endfunction

    function automatic void send_id();
        if ((lk_flags & F_BUSY) != 0)
            return;
        push_byte(1'b1, lk_own_id, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0);
        lk_sum = lk_own_id;
        lk_flags |= F_IDSENT;
    endfunction

    function automatic void close_packet();
        int  n;
        logic ce;
        n  = lk_rx_count;
        ce = (lk_sum != 0);
        for (int i = 0; i < n; i++)
            push_byte(1'b0, 8'h00, 1'b1, lk_rx_mem[5'(i)], (i + 1 == n), ce, lk_overflow);
        lk_rx_count = 0;
        lk_overflow = 1'b0;
        lk_sum      = '0;
        if ((lk_flags & F_PEND) != 0)
        begin
            arm_timer({1'b0, lk_prio});
            lk_flags |= F_PRIO;
        end
    endfunction

    function automatic void timer_done();
        lk_flags &= ~F_BUSY;
        if ((lk_flags & F_BACKOFF) != 0)
        begin
            lk_flags &= ~F_BACKOFF;
            lk_coll = '0;
            send_id();
        end
        else if ((lk_flags & F_PRIO) != 0)
        begin
            lk_flags &= ~F_PRIO;
            send_id();
        end
        else if ((lk_flags & F_XMIT) == 0)
            close_packet();
    endfunction

    function automatic void take_collision();
        logic [7:0] b;
        n_collisions++;
        if (lk_coll != sblc_pkg::COLL_MAX)
            lk_coll++;
        if (lk_coll == 8'd1)
            arm_timer(lk_idle);
        else
        begin
            b = lk_coll & sblc_pkg::BACKOFF_MASK;
            if (b == 0)
                b = 8'd8;
            arm_timer(b[4:0]);
            lk_flags |= F_BACKOFF;
        end
    endfunction

    function automatic void bus_byte(logic [7:0] b);
        lk_flags &= ~(F_PRIO | F_BACKOFF);
        if ((lk_flags & F_XMIT) != 0)
        begin
            if ((lk_flags & F_CSUM) != 0)
                lk_flags &= ~(F_XMIT | F_CSUM | F_WAITIDLE);
        end
        else if ((lk_flags & F_IDSENT) == 0)
        begin
            lk_flags |= F_BUSY;
            arm_timer(lk_idle);
            if (lk_rx_count < STORE_DEPTH)
            begin
                lk_rx_mem[5'(lk_rx_count)] = b;
                lk_rx_count++;
            end
            else
                lk_overflow = 1'b1;
            lk_sum = lk_sum + b;
        end
        if ((lk_flags & F_PEND) != 0 && (lk_flags & F_IDSENT) != 0)
        begin
            lk_flags &= ~F_IDSENT;
            if (b == lk_own_id)
                lk_flags |= F_XMIT;
            else
                take_collision();
        end
    endfunction

    function automatic void uart_free();
        logic [7:0] v;
        if ((lk_flags & F_XMIT) == 0 || (lk_flags & F_CSUM) != 0)
            return;
        if (lk_send_pos < lk_send_len)
        begin
            v = lk_tx_mem[5'(lk_send_pos)];
            push_byte(1'b1, v, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0);
            lk_sum = lk_sum + v;
            lk_send_pos++;
        end
        else
        begin
            lk_send_len = 0;
            push_byte(1'b1, 8'h00 - lk_sum, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0);
            lk_sum = '0;
            lk_flags &= ~F_PEND;
            lk_flags |= F_CSUM;
        end
    endfunction

    function automatic void link_step(sblc_pkg::in_item_t it);
        int n;
        step_bytes.delete();
        case (it.op)
            sblc_pkg::OP_TICK:
                if (lk_run)
                begin
                    lk_cnt = lk_cnt + 5'd1;
                    if (lk_cnt == lk_tgt)
                    begin
                        lk_run = 1'b0;
                        lk_cnt = '0;
                        timer_done();
                    end
                end
            sblc_pkg::OP_RXBYTE: bus_byte(it.data_byte);
            sblc_pkg::OP_READY:  uart_free();
            sblc_pkg::OP_LOAD:   lk_tx_mem[it.tx_index] = it.data_byte;
            sblc_pkg::OP_SEND:
                if ((lk_flags & F_PEND) == 0)
                begin
                    lk_send_len = (it.tx_length > STORE_DEPTH) ? STORE_DEPTH : it.tx_length;
                    lk_send_pos = 0;
                    if ((lk_flags & F_WAITIDLE) == 0 && (lk_flags & F_BUSY) == 0)
                    begin
                        arm_timer(lk_idle);
                        lk_flags |= F_WAITIDLE;
                    end
                    lk_flags |= F_PEND;
                end
            default: ;
        endcase
        if (step_bytes.size() == 0)
            push_byte(1'b0, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0);
        n = step_bytes.size();
        for (int k = 0; k < n; k++)
        begin
            step_bytes[k].send_pending = ((lk_flags & F_PEND) != 0);
            step_bytes[k].bus_busy     = ((lk_flags & F_BUSY) != 0);
            step_bytes[k].last         = (k + 1 == n);
            pending_results.push_back(step_bytes[k]);
        end
    endfunction

    task automatic report(string field, logic [7:0] got, logic [7:0] want);
        n_errors++;
        $display("mismatch at %0t on transfer %0d: %s got %h, expected %h",
                 $realtime, n_results, field, got, want);
    endtask

    always @(posedge clk)
    begin
        sblc_pkg::out_item_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                n_errors++;
                $display("unexpected result transfer at %0t", $realtime);
            end
            else
            begin
                e = pending_results.pop_front();
                if (out_data.tx_valid !== e.tx_valid)
                    report("tx_valid", out_data.tx_valid, e.tx_valid);
                if (out_data.tx_byte !== e.tx_byte)
                    report("tx_byte", out_data.tx_byte, e.tx_byte);
                if (out_data.rx_valid !== e.rx_valid)
                    report("rx_valid", out_data.rx_valid, e.rx_valid);
                if (out_data.rx_byte !== e.rx_byte)
                    report("rx_byte", out_data.rx_byte, e.rx_byte);
                if (out_data.rx_end !== e.rx_end)
                    report("rx_end", out_data.rx_end, e.rx_end);
                if (out_data.checksum_error !== e.checksum_error)
                    report("checksum_error", out_data.checksum_error, e.checksum_error);
                if (out_data.rx_overflow !== e.rx_overflow)
                    report("rx_overflow", out_data.rx_overflow, e.rx_overflow);
                if (out_data.send_pending !== e.send_pending)
                    report("send_pending", out_data.send_pending, e.send_pending);
                if (out_data.bus_busy !== e.bus_busy)
                    report("bus_busy", out_data.bus_busy, e.bus_busy);
                if (out_data.last !== e.last)
                    report("last", out_data.last, e.last);
                if (e.rx_valid)
                    n_rx_bytes++;
                if (e.tx_valid)
                    n_tx_bytes++;
            end
            n_results++;
        end
    end

    // receiver side stall pattern
    initial
    begin
        out_stall   <= 1'b0;
        stall_left  = 0;
        forever
        begin
            @(posedge clk);
            if (hold_cycles > 0)
            begin
                out_stall <= 1'b1;
                hold_cycles--;
            end
            else if (stall_left > 0)
            begin
                out_stall <= 1'b1;
                stall_left--;
            end
            else if (idling && $urandom_range(0, 5) == 0)
            begin
                out_stall  <= 1'b1;
                stall_left = $urandom_range(1, 14) - 1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    task automatic send_op(logic [2:0] op, logic [7:0] data = 8'h00,
                           logic [4:0] idx = 5'd0, logic [5:0] len = 6'd0);
        sblc_pkg::in_item_t it;
        int                 gap;
        it.op        = op;
        it.data_byte = data;
        it.tx_index  = idx;
        it.tx_length = len;
        if (idling && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 14);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do
            @(posedge clk);
        while (in_stall);
        link_step(it);
        n_items++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic set_reg(logic [1:0] idx, logic [7:0] value);
        drain();
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
        case (idx)
            sblc_pkg::CFG_OWN_ID:   lk_own_id = value;
            sblc_pkg::CFG_PRIORITY: lk_prio   = value[3:0];
            sblc_pkg::CFG_IDLE:     lk_idle   = value[4:0];
            default: ;
        endcase
    endtask

    task automatic rx_packet(int n, bit zero_sum);
        logic [7:0] s;
        logic [7:0] b;
        s = '0;
        for (int i = 0; i < n; i++)
        begin
            b = 8'($urandom_range(0, 255));
            if (zero_sum && i == n - 1)
                b = 8'h00 - s;
            s = s + b;
            send_op(sblc_pkg::OP_RXBYTE, b);
        end
        for (int i = 0; i < 40 && (lk_flags & F_BUSY) != 0; i++)
            send_op(sblc_pkg::OP_TICK);
    endtask

    task automatic tx_frame(int len, int clash_pct);
        bit clash;
        send_op(sblc_pkg::OP_SEND, 8'h00, 5'd0, len[5:0]);
        for (int round = 0; round < 6; round++)
        begin
            for (int i = 0; i < 100 && (lk_flags & F_IDSENT) == 0; i++)
                send_op(sblc_pkg::OP_TICK);
            if ((lk_flags & F_IDSENT) == 0)
                return;
            clash = (round < 5) && ($urandom_range(1, 100) <= clash_pct);
            send_op(sblc_pkg::OP_RXBYTE,
                    clash ? lk_own_id ^ 8'($urandom_range(1, 255)) : lk_own_id);
            if (!clash)
            begin
                while ((lk_flags & F_XMIT) != 0 && (lk_flags & F_CSUM) == 0)
                begin
                    if ($urandom_range(0, 3) == 0)
                        send_op(sblc_pkg::OP_RXBYTE, 8'($urandom_range(0, 255)));
                    send_op(sblc_pkg::OP_READY);
                end
                send_op(sblc_pkg::OP_RXBYTE, 8'($urandom_range(0, 255)));
                return;
            end
        end
    endtask

    task automatic noise_op();
        send_op(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
                5'($urandom_range(0, 31)), 6'($urandom_range(0, 63)));
    endtask

    task automatic test_tx_store_load();
        for (int i = 0; i < STORE_DEPTH; i++)
            send_op(sblc_pkg::OP_LOAD,
                    (i == 0) ? 8'h00 : (i == 31) ? 8'hFF : 8'($urandom_range(0, 255)),
                    i[4:0]);
    endtask

    task automatic test_receive();
        send_op(sblc_pkg::OP_RXBYTE, 8'h00);
        send_op(sblc_pkg::OP_RXBYTE, 8'hFF);
        send_op(sblc_pkg::OP_RXBYTE, 8'h01);
        send_op(sblc_pkg::OP_RXBYTE, 8'h55);
        for (int i = 0; i < 12; i++)
            send_op(sblc_pkg::OP_TICK);
        rx_packet(3, 1'b1);
    endtask

    task automatic test_special_ops();
        send_op(sblc_pkg::OP_READY);
        send_op(3'd5, 8'hFF, 5'd31, 6'd63);
        send_op(3'd6, 8'hA5, 5'd10, 6'd33);
        send_op(3'd7, 8'h5A, 5'd21, 6'd40);
    endtask

    task automatic test_transmit();
        tx_frame(2, 0);
        tx_frame(0, 0);
        send_op(sblc_pkg::OP_SEND, 8'h00, 5'd0, 6'd1);
        send_op(sblc_pkg::OP_SEND, 8'h00, 5'd0, 6'd5);
        for (int i = 0; i < 100 && (lk_flags & F_IDSENT) == 0; i++)
            send_op(sblc_pkg::OP_TICK);
        send_op(sblc_pkg::OP_RXBYTE, lk_own_id);
        send_op(sblc_pkg::OP_READY);
        send_op(sblc_pkg::OP_READY);
        send_op(sblc_pkg::OP_RXBYTE, 8'h00);
        tx_frame(63, 0);
    endtask

    task automatic test_overflow_and_collisions();
        rx_packet(36, 1'b0);
        rx_packet(32, 1'b1);
        tx_frame(3, 100);
    endtask

    task automatic test_config_corners();
        set_reg(sblc_pkg::CFG_OWN_ID, 8'h00);
        set_reg(sblc_pkg::CFG_PRIORITY, 8'd1);
        set_reg(sblc_pkg::CFG_IDLE, 8'd1);
        rx_packet(2, 1'b0);
        tx_frame(2, 50);
        set_reg(sblc_pkg::CFG_OWN_ID, 8'hFF);
        set_reg(sblc_pkg::CFG_PRIORITY, 8'd8);
        set_reg(sblc_pkg::CFG_IDLE, 8'd31);
        rx_packet(3, 1'b1);
        tx_frame(1, 50);
        set_reg(sblc_pkg::CFG_OWN_ID, 8'($urandom_range(0, 255)));
        set_reg(sblc_pkg::CFG_PRIORITY, 8'($urandom_range(1, 8)));
        set_reg(sblc_pkg::CFG_IDLE, 8'($urandom_range(2, 12)));
    endtask

    task automatic test_result_backpressure();
        hold_cycles = 400;
        rx_packet(20, 1'b0);
        tx_frame(6, 0);
    endtask

    task automatic random_mix();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 35)
            rx_packet(($urandom_range(0, 9) == 0) ? $urandom_range(30, 40) : $urandom_range(1, 6),
                      1'($urandom_range(0, 1)));
        else if (pick < 80)
            tx_frame(($urandom_range(0, 9) == 0) ? $urandom_range(7, 40) : $urandom_range(0, 6),
                     30);
        else
            repeat ($urandom_range(1, 4)) noise_op();
    endtask

    task automatic test_random();
        int phase_goal;
        phase_goal = n_items + (ITEM_GOAL - n_items) / 3;
        while (n_items < phase_goal)
            random_mix();
        set_reg(sblc_pkg::CFG_IDLE, 8'($urandom_range(1, 6)));
        set_reg(sblc_pkg::CFG_PRIORITY, 8'($urandom_range(1, 3)));
        phase_goal = n_items + (ITEM_GOAL - n_items) / 2;
        while (n_items < phase_goal)
            random_mix();
        idling = 1'b0;
        while (n_items < ITEM_GOAL)
            random_mix();
    endtask

    initial
    begin
        rst_n       = 1'b0;
        in_valid    <= 1'b0;
        in_data     <= '0;
        cfg_write   <= 1'b0;
        cfg_index   <= sblc_pkg::CFG_OWN_ID;
        cfg_data    <= '0;
        hold_cycles = 0;
        n_errors    = 0;
        n_items     = 0;
        n_results   = 0;
        n_rx_bytes  = 0;
        n_tx_bytes  = 0;
        n_collisions = 0;
        idling      = 1'b1;
        lk_own_id   = sblc_pkg::OWN_ID_RESET;
        lk_prio     = sblc_pkg::PRIORITY_RESET;
        lk_idle     = sblc_pkg::IDLE_RESET;
        lk_rx_count = 0;
        lk_overflow = 1'b0;
        lk_send_len = 0;
        lk_send_pos = 0;
        lk_sum      = '0;
        lk_flags    = '0;
        lk_coll     = '0;
        lk_tgt      = '0;
        lk_cnt      = '0;
        lk_run      = 1'b0;
        repeat (10) @(posedge clk);
        rst_n = 1'b1;
        @(posedge clk);

        test_tx_store_load();
        test_receive();
        test_special_ops();
        test_transmit();
        test_overflow_and_collisions();
        test_config_corners();
        test_result_backpressure();
        test_random();

        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (120) @(posedge clk);

        $display("%0d ops sent, %0d result transfers checked", n_items, n_results);
        $display("%0d received bytes, %0d sent bytes, %0d collisions",
                 n_rx_bytes, n_tx_bytes, n_collisions);
        if (n_errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// File: serial_bus_link_controller_top.f
sv/sblc_pkg.sv
sv/sblc_datapath.sv
sv/sblc_ctrl.sv
sv/serial_bus_link_controller_top.sv
tb/sv/serial_bus_link_controller_top_test.sv
